FILE: src/hoa2d_pkg.sv
`default_nettype none

package hoa2d_pkg;

    localparam int DefMaxOrder      = 7;
    localparam int DefMaxChunkLog2  = 12;
    localparam int DefSineTableBits = 10;

    localparam logic [31:0]        HalfPiQ30   = 32'd1686629713;
    localparam longint             OneQ30      = 64'sd1073741824;
    localparam logic signed [31:0] InvSqrt2Q30 = 32'sd759250125;

    typedef enum logic
    {
        REG_ORDER = 1'b0,
        REG_CHUNK = 1'b1
    } reg_idx_t;

    typedef struct packed
    {
        logic signed [23:0] sample;
        logic [15:0]        azimuth;
    } in_t;

    typedef struct packed
    {
        logic [3:0]         channel;
        logic signed [23:0] value;
        logic               last;
    } out_t;

    // one classified item on its way to the back end
    typedef struct packed
    {
        logic signed [23:0] sample;
        logic [15:0]        azimuth;
        logic               start;
        logic [2:0]         order;
        logic [3:0]         lg;
    } job_t;

    typedef struct packed
    {
        logic idle;
    } back_status_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_OMNI,
        ST_RD_SIN,
        ST_RD_COS,
        ST_STEP_RE,
        ST_UPDATE,
        ST_OUT_IM,
        ST_OUT_RE
    } back_state_t;

    // quarter wave sine in q2.30 by taylor series, evaluated at elaboration
    function automatic logic [30:0] quarter_sine(input int unsigned r, input int unsigned bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        logic [30:0] res;
        x    = (64'(r) * 64'(HalfPiQ30)) >> (bits - 2);
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + longint'(term);
        if (sum < 0)
        begin
            res = '0;
        end
        else if (sum > OneQ30)
        begin
            res = 31'(OneQ30);
        end
        else
        begin
            res = 31'(sum);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: src/hoa2d_queue.sv
`default_nettype none

module hoa2d_queue
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire hoa2d_pkg::job_t   push_data,
    output logic                   full,
    input  wire logic              pop,
    output hoa2d_pkg::job_t        pop_data,
    output logic                   q_valid
);

    hoa2d_pkg::job_t mem_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    assign full     = count_reg == 2'd2;
    assign q_valid  = count_reg != 2'd0;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: src/hoa2d_front.sv
`default_nettype none

module hoa2d_front
#(
    parameter int MAX_ORDER      = hoa2d_pkg::DefMaxOrder,
    parameter int MAX_CHUNK_LOG2 = hoa2d_pkg::DefMaxChunkLog2
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire hoa2d_pkg::in_t    in_data,
    input  wire logic [2:0]        cfg_order,
    input  wire logic [3:0]        cfg_chunk,
    input  wire logic              full,
    output logic                   push,
    output hoa2d_pkg::job_t        push_data
);

    localparam int PW = (MAX_CHUNK_LOG2 > 0) ? MAX_CHUNK_LOG2 : 1;

    logic [PW-1:0] pos_reg;
    logic [PW-1:0] pos_next;
    logic [PW-1:0] pos_eff;
    logic [PW:0]   pos_inc;
    logic [PW:0]   chunk_len;
    logic [3:0]    lg;
    logic [2:0]    ord;

    always_comb
    begin
        lg  = (int'(cfg_chunk) > MAX_CHUNK_LOG2) ? 4'(MAX_CHUNK_LOG2) : cfg_chunk;
        ord = (int'(cfg_order) > MAX_ORDER) ? 3'(MAX_ORDER) : cfg_order;
        chunk_len = (PW+1)'(1) << lg;
        // a shortened chunk restarts once the position is past its end
        pos_eff = ({1'b0, pos_reg} >= chunk_len) ? '0 : pos_reg;
        pos_inc = {1'b0, pos_eff} + (PW+1)'(1);
        pos_next = (pos_inc >= chunk_len) ? '0 : pos_inc[PW-1:0];
    end

    assign in_ready = !full;
    assign push     = in_valid && !full;

    always_comb
    begin
        push_data.sample  = in_data.sample;
        push_data.azimuth = in_data.azimuth;
        push_data.start   = pos_eff == '0;
        push_data.order   = ord;
        push_data.lg      = lg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (push)
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/hoa2d_sine_rom.sv
`default_nettype none

module hoa2d_sine_rom
#(
    parameter int SINE_TABLE_BITS = hoa2d_pkg::DefSineTableBits
)
(
    input  wire logic                       clk,
    input  wire logic [SINE_TABLE_BITS-1:0] addr,
    output logic signed [31:0]              rdata
);

    localparam int B       = SINE_TABLE_BITS;
    localparam int Quarter = 1 << (B - 2);

    logic [30:0]        qtab [Quarter+1];
    logic [1:0]         quad;
    logic [B-1:0]       r_m;
    logic signed [31:0] mag;
    logic signed [31:0] rdata_next;

    for (genvar g = 0; g <= Quarter; g++)
    begin : g_tab
        localparam logic [30:0] Val = hoa2d_pkg::quarter_sine(g, B);
        assign qtab[g] = Val;
    end

    always_comb
    begin
        quad = addr[B-1 -: 2];
        r_m  = quad[0] ? (B)'(Quarter) - {2'b00, addr[B-3:0]} : {2'b00, addr[B-3:0]};
        mag  = {1'b0, qtab[r_m[B-2:0]]};
        rdata_next = quad[1] ? -mag : mag;
    end

    always_ff @(posedge clk)
    begin
        rdata <= rdata_next;
    end

endmodule

`default_nettype wire

FILE: src/hoa2d_back.sv
`default_nettype none

module hoa2d_back
#(
    parameter int MAX_ORDER       = hoa2d_pkg::DefMaxOrder,
    parameter int SINE_TABLE_BITS = hoa2d_pkg::DefSineTableBits
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    input  wire hoa2d_pkg::job_t      q_data,
    output logic                      q_pop,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output hoa2d_pkg::out_t           out_data,
    output hoa2d_pkg::back_status_t   status
);

    localparam int KW = $clog2(MAX_ORDER + 1);
    localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int B  = SINE_TABLE_BITS;

    hoa2d_pkg::back_state_t state_reg;
    hoa2d_pkg::back_state_t state_next;

    hoa2d_pkg::job_t    job_reg;
    logic [KW-1:0]      k_reg;
    logic signed [31:0] w_re_reg [MAX_ORDER];
    logic signed [31:0] w_im_reg [MAX_ORDER];
    logic signed [31:0] s_re_reg [MAX_ORDER];
    logic signed [31:0] s_im_reg [MAX_ORDER];
    logic               out_valid_reg;
    hoa2d_pkg::out_t    out_data_reg;
    hoa2d_pkg::out_t    out_data_next;

    logic [IW-1:0]      idx;
    logic               last_k;
    logic [15:0]        angle;
    logic [B-1:0]       sin_idx;
    logic [B-1:0]       rom_addr;
    logic signed [31:0] rom_data;
    logic               out_free;
    logic               load_out;
    logic               k_first;
    logic               k_inc;

    logic signed [31:0] w_sel;
    logic signed [55:0] prod;
    logic signed [55:0] prod_sh;
    logic signed [23:0] prod_sat;

    logic signed [33:0] diff;
    logic signed [33:0] diff_sh;
    logic signed [31:0] step_sat;
    logic signed [32:0] sum_re;
    logic signed [32:0] sum_im;
    logic signed [31:0] sum_re_sat;
    logic signed [31:0] sum_im_sat;

    hoa2d_sine_rom
    #(
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
    )
    u_rom
    (
        .clk  (clk),
        .addr (rom_addr),
        .rdata(rom_data)
    );

    always_comb
    begin
        idx      = IW'(k_reg - KW'(1));
        last_k   = k_reg == KW'(job_reg.order);
        angle    = 16'(32'(k_reg) * 32'(job_reg.azimuth));
        sin_idx  = angle[15 -: B];
        out_free = !out_valid_reg || out_ready;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hoa2d_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = hoa2d_pkg::ST_OMNI;
                end
            end
            hoa2d_pkg::ST_OMNI:
            begin
                if (out_free)
                begin
                    if (job_reg.order == 3'd0)
                    begin
                        state_next = hoa2d_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = job_reg.start ? hoa2d_pkg::ST_RD_SIN : hoa2d_pkg::ST_UPDATE;
                    end
                end
            end
            hoa2d_pkg::ST_RD_SIN:  state_next = hoa2d_pkg::ST_RD_COS;
            hoa2d_pkg::ST_RD_COS:  state_next = hoa2d_pkg::ST_STEP_RE;
            hoa2d_pkg::ST_STEP_RE: state_next = hoa2d_pkg::ST_UPDATE;
            hoa2d_pkg::ST_UPDATE:  state_next = hoa2d_pkg::ST_OUT_IM;
            hoa2d_pkg::ST_OUT_IM:
            begin
                if (out_free)
                begin
                    state_next = hoa2d_pkg::ST_OUT_RE;
                end
            end
            hoa2d_pkg::ST_OUT_RE:
            begin
                if (out_free)
                begin
                    if (last_k)
                    begin
                        state_next = hoa2d_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = job_reg.start ? hoa2d_pkg::ST_RD_SIN : hoa2d_pkg::ST_UPDATE;
                    end
                end
            end
            default: state_next = hoa2d_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        q_pop    = 1'b0;
        rom_addr = sin_idx;
        load_out = 1'b0;
        k_first  = 1'b0;
        k_inc    = 1'b0;
        w_sel    = hoa2d_pkg::InvSqrt2Q30;
        out_data_next.channel = 4'd0;
        out_data_next.last    = 1'b0;
        unique case (state_reg)
            hoa2d_pkg::ST_IDLE:
            begin
                q_pop = q_valid;
            end
            hoa2d_pkg::ST_OMNI:
            begin
                load_out = out_free;
                k_first  = out_free;
                out_data_next.last = job_reg.order == 3'd0;
            end
            hoa2d_pkg::ST_RD_COS:
            begin
                // cosine sits a quarter turn ahead
                rom_addr = sin_idx + B'(1 << (B - 2));
            end
            hoa2d_pkg::ST_OUT_IM:
            begin
                load_out = out_free;
                w_sel    = w_im_reg[idx];
                out_data_next.channel = 4'(2 * int'(k_reg) - 1);
            end
            hoa2d_pkg::ST_OUT_RE:
            begin
                load_out = out_free;
                k_inc    = out_free && !last_k;
                w_sel    = w_re_reg[idx];
                out_data_next.channel = 4'(2 * int'(k_reg));
                out_data_next.last    = last_k;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
        out_data_next.value = prod_sat;
    end

    // x * w in q2.30, rounded half up and saturated
    always_comb
    begin
        prod    = job_reg.sample * w_sel;
        prod_sh = (prod + 56'sd536870912) >>> 30;
        if (prod_sh > 56'sd8388607)
        begin
            prod_sat = 24'sh7FFFFF;
        end
        else if (prod_sh < -56'sd8388608)
        begin
            prod_sat = -24'sh800000;
        end
        else
        begin
            prod_sat = 24'(prod_sh);
        end
    end

    // step toward target: im target is -sin, re target is cos
    always_comb
    begin
        if (state_reg == hoa2d_pkg::ST_RD_COS)
        begin
            diff = -34'(rom_data) - 34'(w_im_reg[idx]);
        end
        else
        begin
            diff = 34'(rom_data) - 34'(w_re_reg[idx]);
        end
        diff_sh = diff >>> job_reg.lg;
        if (diff_sh > 34'sd2147483647)
        begin
            step_sat = 32'sh7FFFFFFF;
        end
        else if (diff_sh < -34'sd2147483648)
        begin
            step_sat = 32'sh80000000;
        end
        else
        begin
            step_sat = 32'(diff_sh);
        end
        sum_re = 33'(w_re_reg[idx]) + 33'(s_re_reg[idx]);
        sum_im = 33'(w_im_reg[idx]) + 33'(s_im_reg[idx]);
        sum_re_sat = (sum_re[32] != sum_re[31]) ? {sum_re[32], {31{~sum_re[32]}}} : sum_re[31:0];
        sum_im_sat = (sum_im[32] != sum_im[31]) ? {sum_im[32], {31{~sum_im[32]}}} : sum_im[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hoa2d_pkg::ST_IDLE;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_ORDER; i++)
            begin
                w_re_reg[i] <= '0;
                w_im_reg[i] <= '0;
                s_re_reg[i] <= '0;
                s_im_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (k_first)
            begin
                k_reg <= KW'(1);
            end
            else if (k_inc)
            begin
                k_reg <= k_reg + KW'(1);
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == hoa2d_pkg::ST_RD_COS)
            begin
                s_im_reg[idx] <= step_sat;
            end
            if (state_reg == hoa2d_pkg::ST_STEP_RE)
            begin
                s_re_reg[idx] <= step_sat;
            end
            if (state_reg == hoa2d_pkg::ST_UPDATE)
            begin
                w_re_reg[idx] <= sum_re_sat;
                w_im_reg[idx] <= sum_im_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_data;
        end
        if (load_out)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_data    = out_data_reg;
    assign status.idle = state_reg == hoa2d_pkg::ST_IDLE;

endmodule

`default_nettype wire

FILE: src/hoa2d_point_source_encoder_unit.sv
`default_nettype none

// 2d ambisonics encoder for one point source. each input item holds a q1.23
// sample and a 16-bit azimuth (full turn = 65536); it yields 2*order+1 result
// items in channel order 0, 1, 2, ..., with last set on the final one. a front
// end tracks the position inside the chunk and queues the item (two deep), so
// input is taken while the back end works. the back end is a sequencer with one
// 24x32 multiplier and one sine rom port: it sends the omni result, then for each
// order updates the weights and sends the sine and cosine parts; on the first
// sample of a chunk each order also reads sine and cosine and sets new steps first.
// results leave through an output register, at most one per cycle, and wait there
// while the sink is not ready. registers on the apb port: 0x0 ambisonic_order
// (reset 1), 0x4 chunk_log2 (reset 6); write them only while the block is idle.
module hoa2d_point_source_encoder_unit
#(
    parameter int MAX_ORDER       = hoa2d_pkg::DefMaxOrder,
    parameter int MAX_CHUNK_LOG2  = hoa2d_pkg::DefMaxChunkLog2,
    parameter int SINE_TABLE_BITS = hoa2d_pkg::DefSineTableBits
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    // input items
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire hoa2d_pkg::in_t   in_data,
    // result items
    output logic                  out_valid,
    input  wire logic             out_ready,
    output hoa2d_pkg::out_t       out_data,
    // configuration
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [2:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [2:0] order_reg;
    logic [3:0] chunk_reg;
    logic       cfg_write;

    hoa2d_pkg::job_t         push_data;
    hoa2d_pkg::job_t         pop_data;
    hoa2d_pkg::back_status_t back_status;
    logic                    push;
    logic                    pop;
    logic                    full;
    logic                    q_valid;

    // register access, no wait states
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (hoa2d_pkg::reg_idx_t'(paddr[2]))
            hoa2d_pkg::REG_ORDER: prdata = {29'd0, order_reg};
            hoa2d_pkg::REG_CHUNK: prdata = {28'd0, chunk_reg};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= 3'd1;
            chunk_reg <= 4'd6;
        end
        else if (cfg_write)
        begin
            unique case (hoa2d_pkg::reg_idx_t'(paddr[2]))
                hoa2d_pkg::REG_ORDER: order_reg <= pwdata[2:0];
                hoa2d_pkg::REG_CHUNK: chunk_reg <= pwdata[3:0];
                default:              order_reg <= order_reg;
            endcase
        end
    end

    // front: chunk tracking and classification
    hoa2d_front
    #(
        .MAX_ORDER     (MAX_ORDER),
        .MAX_CHUNK_LOG2(MAX_CHUNK_LOG2)
    )
    u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .cfg_order(order_reg),
        .cfg_chunk(chunk_reg),
        .full     (full),
        .push     (push),
        .push_data(push_data)
    );

    // short queue between the two halves
    hoa2d_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .full     (full),
        .pop      (pop),
        .pop_data (pop_data),
        .q_valid  (q_valid)
    );

    // back: weight interpolation and channel products
    hoa2d_back
    #(
        .MAX_ORDER      (MAX_ORDER),
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
    )
    u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_data   (pop_data),
        .q_pop    (pop),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .status   (back_status)
    );

    // an accepted item is queued right after
    a_push_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> q_valid)
        else $error("accepted item missing from queue");

    // an idle back end picks up waiting work at once
    a_back_picks_up: assert property (@(posedge clk) disable iff (!rst_n)
        (back_status.idle && q_valid) |=> !back_status.idle)
        else $error("back end idles with queued work");

    // the final channel of an item is always a cosine part or omni
    a_last_even: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.last) |-> !out_data.channel[0])
        else $error("last flag on a sine channel");

endmodule

`default_nettype wire

FILE: test/hoa2d_point_source_encoder_unit_tb.sv
`timescale 1ns / 100ps

module hoa2d_point_source_encoder_unit_tb;

    localparam int ENC_MAX_ORDER = 7;
    localparam int ENC_MAX_LG    = 12;
    localparam int TAB_BITS      = 10;
    localparam int TAB_SIZE      = 1 << TAB_BITS;
    localparam int STALL_LIMIT   = 20000;
    // settle time covers the back end working off its item, two items queued ahead
    localparam int SETTLE_CYCLES = 150;
    localparam longint INV_SQRT2 = 759250125;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    hoa2d_pkg::in_t    in_data;
    logic              out_valid;
    logic              out_ready;
    hoa2d_pkg::out_t   out_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    hoa2d_point_source_encoder_unit uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // encoder state as the testbench sees it
    logic signed [31:0] sine_rom [TAB_SIZE];
    logic signed [31:0] gain_re [ENC_MAX_ORDER];
    logic signed [31:0] gain_im [ENC_MAX_ORDER];
    logic signed [31:0] delta_re [ENC_MAX_ORDER];
    logic signed [31:0] delta_im [ENC_MAX_ORDER];
    int unsigned        chunk_pos;
    logic [2:0]         cfg_order;
    logic [3:0]         cfg_lg;

    hoa2d_pkg::out_t channel_q [$];
    int          mismatch_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          holdoff_cycles;
    int          quiet_cycles;

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // sine of r quarter steps in q2.30 by a taylor series up to x^13
    function automatic logic signed [31:0] quarter_wave(input int unsigned r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      acc;
        x    = (64'(r) * 64'd1686629713) / 64'(TAB_SIZE / 4);
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 3; n <= 13; n += 2)
        begin
            term = ((term * x2) >> 30) / 64'((n - 1) * n);
            acc  = (n % 4 == 3) ? acc - longint'(term) : acc + longint'(term);
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        if (acc > 64'sd1073741824)
        begin
            acc = 64'sd1073741824;
        end
        return 32'(acc);
    endfunction

    function automatic logic signed [31:0] sine_at(input logic [15:0] angle);
        return sine_rom[angle >> (16 - TAB_BITS)];
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return 32'(v);
    endfunction

    // q1.23 times q2.30, rounded half up, saturated to 24 bits
    function automatic logic signed [23:0] weigh(input logic signed [23:0] x,
                                                 input longint w);
        longint p;
        p = (longint'(x) * w + 64'sd536870912) >>> 30;
        if (p > 8388607)
        begin
            p = 8388607;
        end
        if (p < -8388608)
        begin
            p = -8388608;
        end
        return 24'(p);
    endfunction

    // expected channel items for one accepted sample
    task automatic encode_sample(input hoa2d_pkg::in_t it);
        int unsigned        ord;
        int unsigned        lg;
        int unsigned        chunk_len;
        logic [15:0]        ang;
        longint             tgt_re;
        longint             tgt_im;
        hoa2d_pkg::out_t    r;
        ord       = (cfg_order > ENC_MAX_ORDER) ? ENC_MAX_ORDER : cfg_order;
        lg        = (cfg_lg > ENC_MAX_LG) ? ENC_MAX_LG : cfg_lg;
        chunk_len = 1 << lg;
        if (chunk_pos >= chunk_len)
        begin
            chunk_pos = 0;
        end
        if (chunk_pos == 0)
        begin
            for (int k = 1; k <= ord; k++)
            begin
                ang    = 16'(k * it.azimuth);
                tgt_re = sine_at(ang + 16'h4000);
                tgt_im = -longint'(sine_at(ang));
                delta_re[k-1] = clamp32((tgt_re - gain_re[k-1]) >>> lg);
                delta_im[k-1] = clamp32((tgt_im - gain_im[k-1]) >>> lg);
            end
        end
        for (int k = 1; k <= ord; k++)
        begin
            gain_re[k-1] = clamp32(longint'(gain_re[k-1]) + delta_re[k-1]);
            gain_im[k-1] = clamp32(longint'(gain_im[k-1]) + delta_im[k-1]);
        end
        r.channel = 4'd0;
        r.value   = weigh(it.sample, INV_SQRT2);
        r.last    = (ord == 0);
        channel_q.push_back(r);
        for (int k = 1; k <= ord; k++)
        begin
            r.channel = 4'(2 * k - 1);
            r.value   = weigh(it.sample, gain_im[k-1]);
            r.last    = 1'b0;
            channel_q.push_back(r);
            r.channel = 4'(2 * k);
            r.value   = weigh(it.sample, gain_re[k-1]);
            r.last    = (k == ord);
            channel_q.push_back(r);
        end
        chunk_pos++;
        if (chunk_pos >= chunk_len)
        begin
            chunk_pos = 0;
        end
    endtask

    // offer one item, with a random gap first, and wait for acceptance
    task automatic send_sample(input logic signed [23:0] smp, input logic [15:0] az);
        hoa2d_pkg::in_t it;
        it.sample  = smp;
        it.azimuth = az;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = it;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        encode_sample(it);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (channel_q.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // register writes only with the block idle
    task automatic write_reg(input hoa2d_pkg::reg_idx_t idx, input logic [31:0] val);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        paddr   = 3'(idx) << 2;
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        if (idx == hoa2d_pkg::REG_ORDER)
        begin
            cfg_order = val[2:0];
        end
        else
        begin
            cfg_lg = val[3:0];
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    function automatic logic signed [23:0] pick_sample();
        case ($urandom_range(7))
            0:       return 24'sh800000;
            1:       return 24'sh7fffff;
            default: return 24'($urandom);
        endcase
    endfunction

    // extremes of both fields, order zero, chunk length clamp, config changes mid-chunk
    task automatic test_directed();
        send_sample(24'sh7fffff, 16'd0);
        send_sample(24'sh800000, 16'd16384);
        write_reg(hoa2d_pkg::REG_ORDER, 32'd7);
        write_reg(hoa2d_pkg::REG_CHUNK, 32'd0);
        send_sample(24'sh800000, 16'd16384);
        send_sample(24'sh7fffff, 16'd49152);
        send_sample(24'sh000000, 16'd65535);
        send_sample(24'shffffff, 16'd32768);
        send_sample(24'sh000001, 16'd12345);
        send_sample(24'sh800000, 16'd0);
        write_reg(hoa2d_pkg::REG_ORDER, 32'd0);
        send_sample(24'sh7fffff, 16'd8192);
        send_sample(24'sh800000, 16'd100);
        // chunk log2 above the limit acts as the limit
        write_reg(hoa2d_pkg::REG_ORDER, 32'd3);
        write_reg(hoa2d_pkg::REG_CHUNK, 32'd15);
        send_sample(24'sh400000, 16'd30000);
        send_sample(24'shc00000, 16'd30000);
        write_reg(hoa2d_pkg::REG_CHUNK, 32'd13);
        send_sample(24'sh123456, 16'd777);
        // shorter chunk after the position has passed its end
        write_reg(hoa2d_pkg::REG_CHUNK, 32'd6);
        for (int i = 0; i < 6; i++)
        begin
            send_sample(pick_sample(), 16'($urandom));
        end
        write_reg(hoa2d_pkg::REG_CHUNK, 32'd2);
        send_sample(24'sh654321, 16'd40000);
        // order raised mid-chunk keeps stale weights of new orders
        write_reg(hoa2d_pkg::REG_ORDER, 32'd1);
        write_reg(hoa2d_pkg::REG_CHUNK, 32'd3);
        send_sample(24'sh7fffff, 16'd5000);
        send_sample(24'sh7fffff, 16'd5000);
        write_reg(hoa2d_pkg::REG_ORDER, 32'd7);
        send_sample(24'sh7fffff, 16'd5000);
        send_sample(24'sh800000, 16'd5000);
    endtask

    // random samples with azimuths that drift like a moving source
    task automatic test_random(input int ord, input int lg, input int n,
                               input int idle_pct, input int stall_pct);
        logic [15:0] az;
        write_reg(hoa2d_pkg::REG_ORDER, 32'(ord));
        write_reg(hoa2d_pkg::REG_CHUNK, 32'(lg));
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        az = 16'($urandom);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) == 0)
            begin
                az = 16'($urandom);
            end
            else
            begin
                az = az + 16'($urandom_range(2000)) - 16'd1000;
            end
            send_sample(pick_sample(), az);
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // sink holds off long enough to back up the input
    task automatic test_backpressure();
        write_reg(hoa2d_pkg::REG_ORDER, 32'd7);
        write_reg(hoa2d_pkg::REG_CHUNK, 32'd1);
        holdoff_cycles = 3000;
        for (int i = 0; i < 20; i++)
        begin
            send_sample(pick_sample(), 16'($urandom));
        end
        // sender pauses until everything has come out
        wait_drained();
        for (int i = 0; i < 10; i++)
        begin
            send_sample(pick_sample(), 16'($urandom));
        end
    endtask

    // sink side ready pattern
    always @(negedge clk)
    begin
        if (holdoff_cycles > 0)
        begin
            out_ready      <= 1'b0;
            holdoff_cycles <= holdoff_cycles - 1;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // compare each result item with the oldest expected one
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (channel_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("unexpected item: ch %0d val %0d last %0b",
                             out_data.channel, out_data.value, out_data.last);
                end
            end
            else if (out_data !== channel_q[0])
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("item mismatch: exp ch %0d val %0d last %0b, got ch %0d val %0d last %0b",
                             channel_q[0].channel, channel_q[0].value, channel_q[0].last,
                             out_data.channel, out_data.value, out_data.last);
                end
                void'(channel_q.pop_front());
            end
            else
            begin
                void'(channel_q.pop_front());
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < TAB_SIZE; i++)
        begin
            case (i / (TAB_SIZE / 4))
                0: sine_rom[i] = quarter_wave(i % (TAB_SIZE / 4));
                1: sine_rom[i] = quarter_wave(TAB_SIZE / 4 - i % (TAB_SIZE / 4));
                2: sine_rom[i] = -quarter_wave(i % (TAB_SIZE / 4));
                default: sine_rom[i] = -quarter_wave(TAB_SIZE / 4 - i % (TAB_SIZE / 4));
            endcase
        end
        for (int k = 0; k < ENC_MAX_ORDER; k++)
        begin
            gain_re[k]  = '0;
            gain_im[k]  = '0;
            delta_re[k] = '0;
            delta_im[k] = '0;
        end
        chunk_pos      = 0;
        cfg_order      = 3'd1;
        cfg_lg         = 4'd6;
        mismatch_count = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holdoff_cycles = 0;
        quiet_cycles   = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(2, 3, 90, 0, 0);
        test_random(7, 0, 90, 80, 0);
        test_random(5, 12, 90, 0, 80);
        test_random(0, 4, 40, 7, 7);
        test_random(3, 2, 60, 7, 7);
        test_backpressure();

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        mismatch_count += channel_q.size();
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: files.f
src/hoa2d_pkg.sv
src/hoa2d_queue.sv
src/hoa2d_front.sv
src/hoa2d_sine_rom.sv
src/hoa2d_back.sv
src/hoa2d_point_source_encoder_unit.sv
test/hoa2d_point_source_encoder_unit_tb.sv
